>>> rtl/nfcrfp_pkg.sv
// ----------------------------------------------------------------------------
// nfcrfp_pkg
// Shared types and codes for the NFC response frame parser.
// ----------------------------------------------------------------------------
package nfcrfp_pkg;

	localparam logic [7:0] START_ZERO = 8'h00;
	localparam logic [7:0] START_CODE = 8'hFF;

	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_GOOD    = 3'd2,
		ST_LCS_ERR = 3'd3,
		ST_DCS_ERR = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		PH_HUNT     = 6'b000001,
		PH_GOT_ZERO = 6'b000010,
		PH_LEN      = 6'b000100,
		PH_LCS      = 6'b001000,
		PH_DATA     = 6'b010000,
		PH_DCS      = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} rx_beat_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_length;
	} result_t;

endpackage

>>> rtl/nfcrfp_in_stage.sv
// ----------------------------------------------------------------------------
// nfcrfp_in_stage
// Input register: captures one received beat and holds it until taken.
// ----------------------------------------------------------------------------
module nfcrfp_in_stage
	import nfcrfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  rx_beat_t beat,
	input  logic     take,
	output logic     valid_s1,
	output rx_beat_t beat_s1
);

	logic load;

	assign byte_stall = valid_s1 && !take;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= beat;
		end
	end

endmodule

>>> rtl/nfcrfp_deframer.sv
// ----------------------------------------------------------------------------
// nfcrfp_deframer
// Frame state and per-beat decode: start code hunt, length check, payload
// indexing and data checksum.
// ----------------------------------------------------------------------------
module nfcrfp_deframer
	import nfcrfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  rx_beat_t beat,
	output result_t  result
);

	phase_t     phase_q, cur_phase, nxt_phase;
	logic [7:0] remaining_q, cur_rem, nxt_rem;
	logic [7:0] sum_q, cur_sum, nxt_sum;
	logic [7:0] count_q, cur_cnt, nxt_cnt;
	logic [7:0] lcs_sum, dcs_sum, rem_dec, sum_add, cnt_inc;
	logic [7:0] b;

	assign b         = beat.rx_byte;
	assign cur_phase = beat.restart ? PH_HUNT : phase_q;
	assign cur_rem   = beat.restart ? 8'd0 : remaining_q;
	assign cur_sum   = beat.restart ? 8'd0 : sum_q;
	assign cur_cnt   = beat.restart ? 8'd0 : count_q;

	assign lcs_sum = cur_rem + b;
	assign dcs_sum = cur_sum + b;
	assign rem_dec = cur_rem - 8'd1;
	assign sum_add = cur_sum + b;
	assign cnt_inc = cur_cnt + 8'd1;

	always_comb begin
		nxt_phase = cur_phase;
		nxt_rem   = cur_rem;
		nxt_sum   = cur_sum;
		nxt_cnt   = cur_cnt;
		result    = '{status: ST_HEADER, payload_byte: 8'd0, byte_index: 8'd0,
			frame_length: 8'd0};
		case (cur_phase)
			PH_GOT_ZERO: begin
				if (b == START_CODE) begin
					nxt_phase = PH_LEN;
				end else if (b != START_ZERO) begin
					nxt_phase = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (b != 8'd0) begin
					nxt_rem   = b;
					nxt_phase = PH_LCS;
				end else begin
					nxt_phase = PH_HUNT;
				end
			end
			PH_LCS: begin
				if (lcs_sum == 8'd0) begin
					nxt_sum   = 8'd0;
					nxt_cnt   = 8'd0;
					nxt_phase = PH_DATA;
				end else begin
					result.status = ST_LCS_ERR;
					nxt_phase     = PH_HUNT;
				end
			end
			PH_DATA: begin
				result.status       = ST_PAYLOAD;
				result.payload_byte = b;
				result.byte_index   = cur_cnt;
				nxt_cnt             = cnt_inc;
				nxt_sum             = sum_add;
				nxt_rem             = rem_dec;
				if (rem_dec == 8'd0) begin
					nxt_phase = PH_DCS;
				end
			end
			PH_DCS: begin
				if (dcs_sum == 8'd0) begin
					result.status       = ST_GOOD;
					result.frame_length = cur_cnt;
				end else begin
					result.status = ST_DCS_ERR;
				end
				nxt_phase = PH_HUNT;
			end
			default: begin
				nxt_phase = (b == START_ZERO) ? PH_GOT_ZERO : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			remaining_q <= 8'd0;
			sum_q       <= 8'd0;
			count_q     <= 8'd0;
		end else if (step) begin
			phase_q     <= nxt_phase;
			remaining_q <= nxt_rem;
			sum_q       <= nxt_sum;
			count_q     <= nxt_cnt;
		end
	end

endmodule

>>> rtl/nfcrfp_out_stage.sv
// ----------------------------------------------------------------------------
// nfcrfp_out_stage
// Result register: holds one decoded beat until the consumer takes it.
// ----------------------------------------------------------------------------
module nfcrfp_out_stage
	import nfcrfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t result,
	output logic    take,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_s2
);

	assign take = valid_s1 && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2 <= result;
		end
	end

endmodule

>>> rtl/nfc_response_frame_parser.sv
// ----------------------------------------------------------------------------
// nfc_response_frame_parser
// Deframes controller information frames from a received byte stream.
//
//   channel   direction  handshake                 payload
//   rx        in         byte_valid / byte_stall   rx_byte, restart
//   result    out        result_valid / result_stall
//                                                  status, payload_byte,
//                                                  byte_index, frame_length
//
// One beat in, one result out; a beat can be taken every cycle while results are not stalled.
// Path: input register, then decode into the result register.
// Frame state updates when a beat moves from the input to the result register.
// A stalled result holds; one more beat parks in the input register.
// Reset returns to hunting with both registers empty.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser
	import nfcrfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] rx_byte,
	input  logic       restart,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] status,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic [7:0] frame_length
);

	rx_beat_t beat, beat_s1;
	result_t  result, result_s2;
	logic     valid_s1;
	logic     take;

	assign beat = '{rx_byte: rx_byte, restart: restart};

	nfcrfp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.beat       (beat),
		.take       (take),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	nfcrfp_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.beat   (beat_s1),
		.result (result)
	);

	nfcrfp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.result       (result),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_s2    (result_s2)
	);

	assign status       = result_s2.status;
	assign payload_byte = result_s2.payload_byte;
	assign byte_index   = result_s2.byte_index;
	assign frame_length = result_s2.frame_length;

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_good_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_s2.status == ST_GOOD) |-> frame_length != 8'd0)
		else $error("good frame with zero length");

	a_non_payload_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_s2.status != ST_PAYLOAD)
			|-> (payload_byte == 8'd0) && (byte_index == 8'd0))
		else $error("payload fields set outside payload beat");

endmodule

>>> tb/nfc_response_frame_parser_check.sv
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_check
// Watches both channels of the frame parser, keeps its own copy of the frame
// state and predicts one result per accepted byte. Each accepted result beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_check
	import nfcrfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] rx_byte,
	input  logic       restart,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic [2:0] status,
	input  logic [7:0] payload_byte,
	input  logic [7:0] byte_index,
	input  logic [7:0] frame_length,
	output int         results_due = 0,
	output int         mismatch_count = 0
);

	phase_t     hunt_phase = PH_HUNT;
	logic [7:0] bytes_left = '0;
	logic [7:0] data_sum = '0;
	logic [7:0] data_count = '0;
	result_t    frame_results_due[$];

	function automatic void clear_frame();
		hunt_phase = PH_HUNT;
		bytes_left = '0;
		data_sum = '0;
		data_count = '0;
	endfunction

	function automatic result_t deframe_byte(logic [7:0] b, logic clear);
		result_t    r;
		logic [7:0] total;
		r = '0;
		r.status = ST_HEADER;
		if (clear)
			clear_frame();
		case (hunt_phase)
			PH_GOT_ZERO: begin
				if (b == START_CODE)
					hunt_phase = PH_LEN;
				else if (b != START_ZERO)
					hunt_phase = PH_HUNT;
			end
			PH_LEN: begin
				if (b != START_ZERO) begin
					bytes_left = b;
					hunt_phase = PH_LCS;
				end else begin
					hunt_phase = PH_HUNT;
				end
			end
			PH_LCS: begin
				total = bytes_left + b;
				if (total == START_ZERO) begin
					data_sum = '0;
					data_count = '0;
					hunt_phase = PH_DATA;
				end else begin
					r.status = ST_LCS_ERR;
					hunt_phase = PH_HUNT;
				end
			end
			PH_DATA: begin
				r.status = ST_PAYLOAD;
				r.payload_byte = b;
				r.byte_index = data_count;
				data_count = data_count + 8'd1;
				data_sum = data_sum + b;
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == START_ZERO)
					hunt_phase = PH_DCS;
			end
			PH_DCS: begin
				total = data_sum + b;
				if (total == START_ZERO) begin
					r.status = ST_GOOD;
					r.frame_length = data_count;
				end else begin
					r.status = ST_DCS_ERR;
				end
				hunt_phase = PH_HUNT;
			end
			default: begin
				hunt_phase = (b == START_ZERO) ? PH_GOT_ZERO : PH_HUNT;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_frame();
			frame_results_due.delete();
			results_due = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (frame_results_due.size() == 0) begin
					$error("result beat with none due: status %0d", status);
					mismatch_count++;
				end else begin
					want = frame_results_due.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("byte_index", want.byte_index, byte_index);
					check_field("frame_length", want.frame_length, frame_length);
				end
			end
			if (byte_valid && !byte_stall)
				frame_results_due.push_back(deframe_byte(rx_byte, restart));
			results_due = frame_results_due.size();
		end
	end

endmodule

>>> tb/nfc_response_frame_parser_test.sv
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_test
// Feeds the frame parser a byte stream of directed header and checksum cases
// followed by random frames, flawed frames and noise, with random idling on
// both sides and one long result hold-off. A checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_test;
	import nfcrfp_pkg::*;

	localparam int LIMIT = 100000;
	localparam int STREAM_ITEMS = 1700;

	typedef enum int {
		FLAW_NONE,
		FLAW_LCS,
		FLAW_DCS,
		FLAW_ZERO_LEN,
		FLAW_RESTART
	} frame_flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] rx_byte = '0;
	logic       restart = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic [7:0] frame_length;

	int         results_due;
	int         mismatch_count;
	int         cycle = 0;
	int         next_beat = 0;
	logic       holding_off = 1'b0;
	logic       quiet;
	rx_beat_t   rx_stream[$];

	nfc_response_frame_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.rx_byte      (rx_byte),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length)
	);

	nfc_response_frame_parser_check checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.rx_byte        (rx_byte),
		.restart        (restart),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.frame_length   (frame_length),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	always #2 clk = ~clk;

	assign quiet = (cycle >= 2000) && (cycle < 2600);

	task automatic push_beat(logic [7:0] b, logic clear);
		rx_beat_t beat;
		beat.rx_byte = b;
		beat.restart = clear;
		rx_stream.push_back(beat);
	endtask

	task automatic push_frame(int len, frame_flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] b;
		int         cut;
		sum = '0;
		cut = (flaw == FLAW_RESTART) ? $urandom_range(len) : -1;
		repeat ($urandom_range(3))
			push_beat(START_ZERO, 1'b0);
		push_beat(START_ZERO, 1'b0);
		push_beat(START_CODE, 1'b0);
		if (flaw == FLAW_ZERO_LEN) begin
			push_beat(START_ZERO, 1'b0);
			return;
		end
		push_beat(8'(len), 1'b0);
		b = 8'd0 - 8'(len);
		if (flaw == FLAW_LCS)
			b = b + 8'($urandom_range(1, 255));
		push_beat(b, 1'b0);
		if (flaw == FLAW_LCS)
			return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			push_beat(b, i == cut);
		end
		b = 8'd0 - sum;
		if (flaw == FLAW_DCS)
			b = b + 8'($urandom_range(1, 255));
		push_beat(b, cut == len);
	endtask

	task automatic build_stream();
		int          big_frames;
		int          pick;
		int          len;
		frame_flaw_t flaw;
		big_frames = 0;
		// good one-byte frame, then FF with no zero before it
		push_frame(1, FLAW_NONE);
		push_beat(START_CODE, 1'b0);
		// zero length
		push_beat(START_ZERO, 1'b0);
		push_beat(START_CODE, 1'b0);
		push_beat(START_ZERO, 1'b0);
		// bad length checksum
		push_frame(2, FLAW_LCS);
		// neither FF nor 00 after a zero
		push_beat(START_ZERO, 1'b0);
		push_beat(8'h5A, 1'b0);
		// bad data checksum with all-ones payload
		push_beat(START_ZERO, 1'b0);
		push_beat(START_CODE, 1'b0);
		push_beat(8'h01, 1'b0);
		push_beat(START_CODE, 1'b0);
		push_beat(START_CODE, 1'b0);
		push_beat(8'h7F, 1'b0);
		// restart in the middle of a payload
		push_beat(START_ZERO, 1'b0);
		push_beat(START_CODE, 1'b0);
		push_beat(8'h02, 1'b0);
		push_beat(8'hFE, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(START_ZERO, 1'b1);
		push_beat(START_CODE, 1'b0);
		while (rx_stream.size() < STREAM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				if (big_frames < 3 && $urandom_range(99) < 2) begin
					len = 255;
					big_frames++;
				end else if ($urandom_range(9) == 0) begin
					len = $urandom_range(1, 64);
				end else begin
					len = $urandom_range(1, 16);
				end
				pick = $urandom_range(99);
				if (pick < 60)
					flaw = FLAW_NONE;
				else if (pick < 73)
					flaw = FLAW_LCS;
				else if (pick < 86)
					flaw = FLAW_DCS;
				else if (pick < 92)
					flaw = FLAW_ZERO_LEN;
				else
					flaw = FLAW_RESTART;
				push_frame(len, flaw);
			end else begin
				repeat ($urandom_range(1, 8))
					push_beat(8'($urandom), $urandom_range(9) == 0);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// drive the next beat once the current one is taken; hold a stalled beat
	always @(posedge clk) begin
		if (arst_n && !(byte_valid && byte_stall)) begin
			if (next_beat < rx_stream.size() && (quiet || $urandom_range(99) >= 29)) begin
				byte_valid <= 1'b1;
				rx_byte <= rx_stream[next_beat].rx_byte;
				restart <= rx_stream[next_beat].restart;
				next_beat <= next_beat + 1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			result_stall <= holding_off || (!quiet && $urandom_range(99) < 29);
	end

	initial begin
		wait (arst_n);
		repeat (700) @(posedge clk);
		holding_off <= 1'b1;
		repeat (300) @(posedge clk);
		holding_off <= 1'b0;
	end

	initial begin
		build_stream();
		wait (next_beat == rx_stream.size() && !byte_valid);
		wait (results_due == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
